// ===== hw/rtl/kd_knn_node_visit_heap_defines.svh =====
// assertion macros for the knn heap checker
`ifndef KD_KNN_NODE_VISIT_HEAP_DEFINES_SVH
`define KD_KNN_NODE_VISIT_HEAP_DEFINES_SVH

// same-cycle implication
`define KNNH_AST_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("knnh check failed");

// next-cycle implication
`define KNNH_AST_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("knnh check failed");

`endif

// ===== hw/rtl/knnh_pkg.sv =====
// shared types and constants of the knn node visit heap
package knnh_pkg;

  localparam int MAX_K_DEF      = 64;
  localparam int COORD_BITS_DEF = 20;
  localparam int ID_BITS_DEF    = 16;

  localparam int DIST_W  = 44;
  localparam int LIMIT_W = 7;
  localparam int SLOT_W  = 7;
  localparam int CFG_W   = 44;
  localparam int CFG_IW  = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [CFG_IW-1:0] REG_QUERY_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_QUERY_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_QUERY_Z = 3'd2;
  localparam logic [CFG_IW-1:0] REG_RADIUS  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LIMIT   = 3'd4;

  localparam logic [1:0] MUL_X    = 2'd0;
  localparam logic [1:0] MUL_Y    = 2'd1;
  localparam logic [1:0] MUL_Z    = 2'd2;
  localparam logic [1:0] MUL_AXIS = 2'd3;

  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_clr;
    logic       acc_add;
    logic       neg_ld;
    logic       dist_ld;
    logic       rd_root;
    logic       up_start;
    logic       dn_start;
    logic       rd_par;
    logic       up_move;
    logic       wr_new;
    logic       rd_l;
    logic       ld_l;
    logic       rd_r;
    logic       ld_r;
    logic       dn_move;
    logic       rad_new;
    logic       rad_child;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic in_rad;
    logic full;
    logic le_root;
    logic i_gt1;
    logic i_is1;
    logic d_gt_rd;
    logic has_l;
    logic has_r;
    logic r_gt;
    logic d_ge_ch;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/knnh_ram.sv =====
// generic single-write single-read ram with registered read data
module knnh_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/knnh_ctrl.sv =====
// controller state machine of the knn node visit heap
module knnh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  knnh_pkg::sts_t sts_i,
  output knnh_pkg::cmd_t cmd_o
);
  import knnh_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MX     = 4'd1;
  localparam logic [3:0] S_MY     = 4'd2;
  localparam logic [3:0] S_MZ     = 4'd3;
  localparam logic [3:0] S_MA     = 4'd4;
  localparam logic [3:0] S_DIST   = 4'd5;
  localparam logic [3:0] S_DEC    = 4'd6;
  localparam logic [3:0] S_UP_CHK = 4'd7;
  localparam logic [3:0] S_UP_CMP = 4'd8;
  localparam logic [3:0] S_DN_CHK = 4'd9;
  localparam logic [3:0] S_DN_L   = 4'd10;
  localparam logic [3:0] S_DN_R   = 4'd11;
  localparam logic [3:0] S_DN_CMP = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  logic [3:0] state_q, state_d;
  cmd_t       cmd;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = sts_i.is_read ? S_FIN : S_MX;
        end
      end
      S_MX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        cmd.acc_clr = 1'b1;
        state_d     = S_MY;
      end
      S_MY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
        cmd.acc_add = 1'b1;
        state_d     = S_MZ;
      end
      S_MZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Z;
        cmd.acc_add = 1'b1;
        state_d     = S_MA;
      end
      S_MA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AXIS;
        cmd.acc_add = 1'b1;
        cmd.neg_ld  = 1'b1;
        state_d     = S_DIST;
      end
      S_DIST: begin
        cmd.dist_ld = 1'b1;
        cmd.rd_root = 1'b1;
        state_d     = S_DEC;
      end
      S_DEC: begin
        priority if (!sts_i.in_rad) begin
          state_d = S_FIN;
        end else if (!sts_i.full) begin
          cmd.up_start = 1'b1;
          state_d      = S_UP_CHK;
        end else if (sts_i.le_root) begin
          cmd.dn_start = 1'b1;
          state_d      = S_DN_CHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_UP_CHK: begin
        if (sts_i.i_gt1) begin
          cmd.rd_par = 1'b1;
          state_d    = S_UP_CMP;
        end else begin
          cmd.wr_new = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_UP_CMP: begin
        if (sts_i.d_gt_rd) begin
          cmd.up_move = 1'b1;
          state_d     = S_UP_CHK;
        end else begin
          cmd.wr_new = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_DN_CHK: begin
        if (sts_i.has_l) begin
          cmd.rd_l = 1'b1;
          state_d  = S_DN_L;
        end else begin
          cmd.wr_new  = 1'b1;
          cmd.rad_new = sts_i.i_is1;
          state_d     = S_FIN;
        end
      end
      S_DN_L: begin
        cmd.ld_l = 1'b1;
        if (sts_i.has_r) begin
          cmd.rd_r = 1'b1;
          state_d  = S_DN_R;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_R: begin
        cmd.ld_r = sts_i.r_gt;
        state_d  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.d_ge_ch) begin
          cmd.wr_new  = 1'b1;
          cmd.rad_new = sts_i.i_is1;
          state_d     = S_FIN;
        end else begin
          cmd.dn_move   = 1'b1;
          cmd.rad_child = sts_i.i_is1;
          state_d       = S_DN_CHK;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd.out_ld = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/knnh_dp.sv =====
// datapath of the knn node visit heap: config, distance unit, heap memory, result word
module knnh_dp #(
  parameter int MAX_K      = knnh_pkg::MAX_K_DEF,
  parameter int COORD_BITS = knnh_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = knnh_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [knnh_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [knnh_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          req_type_i,
  input  logic                          first_node_i,
  input  logic [ID_BITS-1:0]            node_id_i,
  input  logic signed [COORD_BITS-1:0]  node_x_i,
  input  logic signed [COORD_BITS-1:0]  node_y_i,
  input  logic signed [COORD_BITS-1:0]  node_z_i,
  input  logic [1:0]                    split_axis_i,
  input  logic                          has_left_i,
  input  logic                          has_right_i,
  input  logic [knnh_pkg::SLOT_W-1:0]   read_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          visit_left_o,
  output logic                          visit_right_o,
  output logic [knnh_pkg::SLOT_W-1:0]   found_count_o,
  output logic [knnh_pkg::DIST_W-1:0]   radius_sq_o,
  output logic [ID_BITS-1:0]            slot_node_id_o,
  output logic [knnh_pkg::DIST_W-1:0]   slot_dist_sq_o,
  input  knnh_pkg::cmd_t                cmd_i,
  output knnh_pkg::sts_t                sts_o
);
  import knnh_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int PW     = 2 * C;
  localparam int ACC_W  = (PW + 2 > DIST_W + 1) ? PW + 2 : DIST_W + 1;
  localparam int IW     = $clog2(MAX_K + 1);
  localparam int AW     = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int EW     = ID_BITS + DIST_W;

  logic signed [C-1:0] qx_q, qy_q, qz_q;
  logic [DIST_W-1:0]   init_rad_q;
  logic [LIMIT_W-1:0]  limit_q;

  logic                it_read_q, slot_ok_q, it_hl_q, it_hr_q;
  logic [ID_BITS-1:0]  it_id_q;
  logic signed [C-1:0] it_x_q, it_y_q, it_z_q;
  logic [1:0]          it_axis_q;

  logic [IW-1:0]       count_q;
  logic [DIST_W-1:0]   radius_q;
  logic [PW-1:0]       prod_q, d0sq_q;
  logic [ACC_W-1:0]    acc_q;
  logic                d0neg_q;
  logic [DIST_W-1:0]   dist_q;
  logic [IW-1:0]       idx_q, cidx_q;
  logic [ID_BITS-1:0]  ch_id_q;
  logic [DIST_W-1:0]   ch_dist_q;

  logic                out_valid_q, vl_q, vr_q;
  logic [SLOT_W-1:0]   fc_q;
  logic [DIST_W-1:0]   rad_out_q, sdist_q;
  logic [ID_BITS-1:0]  sid_q;

  logic signed [C-1:0] op_q, op_n;
  logic signed [C:0]   diff;
  logic [C:0]          mag;
  logic [PW-1:0]       prod_d;
  logic [DIST_W-1:0]   dist_sat;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_wa, ram_ra;
  logic [EW-1:0]       ram_wd, ram_rd;
  logic [ID_BITS-1:0]  rd_id;
  logic [DIST_W-1:0]   rd_dist;

  logic [IW:0]         left_idx, right_idx, n_ext;
  logic [IW:0]         idx_m1, par_m1, left_m1;
  logic [31:0]         slot_m1, eff_lim;
  logic                slot_ok, near, accept_visit;

  // operand selection for the shared multiplier
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_X: begin
        op_q = qx_q;
        op_n = it_x_q;
      end
      MUL_Y: begin
        op_q = qy_q;
        op_n = it_y_q;
      end
      MUL_Z: begin
        op_q = qz_q;
        op_n = it_z_q;
      end
      default: begin
        if (it_axis_q == AXIS_Y) begin
          op_q = qy_q;
          op_n = it_y_q;
        end else if (it_axis_q == AXIS_Z) begin
          op_q = qz_q;
          op_n = it_z_q;
        end else begin
          op_q = qx_q;
          op_n = it_x_q;
        end
      end
    endcase
  end

  assign diff   = (C+1)'(op_q) - (C+1)'(op_n);
  assign mag    = diff[C] ? -diff : diff;
  assign prod_d = mag[C-1:0] * mag[C-1:0];
  assign dist_sat = (acc_q > ACC_W'(DIST_MAX)) ? DIST_MAX : acc_q[DIST_W-1:0];

  assign rd_id   = ram_rd[EW-1:DIST_W];
  assign rd_dist = ram_rd[DIST_W-1:0];

  assign left_idx  = {idx_q, 1'b0};
  assign right_idx = {idx_q, 1'b1};
  assign n_ext     = (IW+1)'(count_q);
  assign idx_m1    = (IW+1)'(idx_q) - (IW+1)'(1);
  assign par_m1    = (IW+1)'(idx_q >> 1) - (IW+1)'(1);
  assign left_m1   = left_idx - (IW+1)'(1);
  assign slot_m1   = 32'(read_slot_i) - 32'd1;
  assign slot_ok   = (read_slot_i != '0) && (32'(read_slot_i) <= MAX_K);

  always_comb begin
    if (limit_q == '0) begin
      eff_lim = 32'd1;
    end else if (32'(limit_q) > MAX_K) begin
      eff_lim = MAX_K;
    end else begin
      eff_lim = 32'(limit_q);
    end
  end

  // heap memory ports
  always_comb begin
    ram_re = 1'b1;
    ram_ra = '0;
    priority if (cmd_i.accept) begin
      ram_ra = slot_m1[AW-1:0];
    end else if (cmd_i.rd_par) begin
      ram_ra = par_m1[AW-1:0];
    end else if (cmd_i.rd_l) begin
      ram_ra = left_m1[AW-1:0];
    end else if (cmd_i.rd_r) begin
      ram_ra = left_idx[AW-1:0];
    end else if (cmd_i.rd_root) begin
      ram_ra = '0;
    end else begin
      ram_re = 1'b0;
    end
  end

  always_comb begin
    ram_we = cmd_i.wr_new | cmd_i.up_move | cmd_i.dn_move;
    ram_wa = idx_m1[AW-1:0];
    priority if (cmd_i.up_move) begin
      ram_wd = ram_rd;
    end else if (cmd_i.dn_move) begin
      ram_wd = {ch_id_q, ch_dist_q};
    end else begin
      ram_wd = {it_id_q, dist_q};
    end
  end

  knnh_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_K),
    .ADDR_W(AW)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .wr_addr_i(ram_wa),
    .wr_data_i(ram_wd),
    .re_i     (ram_re),
    .rd_addr_i(ram_ra),
    .rd_data_o(ram_rd)
  );

  assign accept_visit = cmd_i.accept & ~req_type_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q       <= '0;
      qy_q       <= '0;
      qz_q       <= '0;
      init_rad_q <= '0;
      limit_q    <= LIMIT_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_QUERY_X: qx_q       <= cfg_data_i[C-1:0];
        REG_QUERY_Y: qy_q       <= cfg_data_i[C-1:0];
        REG_QUERY_Z: qz_q       <= cfg_data_i[C-1:0];
        REG_RADIUS:  init_rad_q <= cfg_data_i[DIST_W-1:0];
        REG_LIMIT:   limit_q    <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      radius_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_visit && first_node_i) begin
        count_q  <= '0;
        radius_q <= init_rad_q;
      end else if (cmd_i.up_start) begin
        count_q <= count_q + IW'(1);
      end
      if (cmd_i.rad_new) begin
        radius_q <= dist_q;
      end else if (cmd_i.rad_child) begin
        radius_q <= ch_dist_q;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      it_read_q <= req_type_i;
      slot_ok_q <= slot_ok;
      it_id_q   <= node_id_i;
      it_x_q    <= node_x_i;
      it_y_q    <= node_y_i;
      it_z_q    <= node_z_i;
      it_axis_q <= split_axis_i;
      it_hl_q   <= has_left_i;
      it_hr_q   <= has_right_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.neg_ld) begin
      d0neg_q <= diff[C];
    end
    if (cmd_i.dist_ld) begin
      dist_q <= dist_sat;
      d0sq_q <= prod_q;
    end
    if (cmd_i.up_start) begin
      idx_q <= count_q + IW'(1);
    end else if (cmd_i.dn_start) begin
      idx_q <= IW'(1);
    end else if (cmd_i.up_move) begin
      idx_q <= idx_q >> 1;
    end else if (cmd_i.dn_move) begin
      idx_q <= cidx_q;
    end
    if (cmd_i.ld_l) begin
      ch_id_q   <= rd_id;
      ch_dist_q <= rd_dist;
      cidx_q    <= left_idx[IW-1:0];
    end else if (cmd_i.ld_r) begin
      ch_id_q   <= rd_id;
      ch_dist_q <= rd_dist;
      cidx_q    <= right_idx[IW-1:0];
    end
  end

  assign near = ACC_W'(d0sq_q) < ACC_W'(radius_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      fc_q      <= SLOT_W'(count_q);
      rad_out_q <= radius_q;
      if (it_read_q) begin
        vl_q    <= 1'b0;
        vr_q    <= 1'b0;
        sid_q   <= slot_ok_q ? rd_id : '0;
        sdist_q <= slot_ok_q ? rd_dist : '0;
      end else begin
        vl_q    <= d0neg_q ? it_hl_q : (it_hl_q & near);
        vr_q    <= d0neg_q ? (it_hr_q & near) : it_hr_q;
        sid_q   <= '0;
        sdist_q <= '0;
      end
    end
  end

  assign sts_o.is_read  = req_type_i;
  assign sts_o.in_rad   = dist_q <= radius_q;
  assign sts_o.full     = 32'(count_q) >= eff_lim;
  assign sts_o.le_root  = dist_q <= rd_dist;
  assign sts_o.i_gt1    = idx_q > IW'(1);
  assign sts_o.i_is1    = idx_q == IW'(1);
  assign sts_o.d_gt_rd  = dist_q > rd_dist;
  assign sts_o.has_l    = left_idx <= n_ext;
  assign sts_o.has_r    = right_idx <= n_ext;
  assign sts_o.r_gt     = ch_dist_q < rd_dist;
  assign sts_o.d_ge_ch  = dist_q >= ch_dist_q;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign visit_left_o   = vl_q;
  assign visit_right_o  = vr_q;
  assign found_count_o  = fc_q;
  assign radius_sq_o    = rad_out_q;
  assign slot_node_id_o = sid_q;
  assign slot_dist_sq_o = sdist_q;

endmodule

// ===== hw/rtl/kd_knn_node_visit_heap.sv =====
// top level of the kd-tree knn node visit with bounded max-heap
//
//  channel  | direction | handshake              | contents
//  cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//  in       | in        | in_valid_i/in_ready_o  | one request word
//  out      | out       | out_valid_o/out_ready_i| one result word
//
// read request: accept, then result register load
// visit: accept, four products on one shared multiplier, distance load, decide,
//   any sift-up or sift-down levels, then result load
// one word at a time; a finished word waits in the output register while the next is taken
// reset clears control, config (limit to 64), count, radius; heap ram has no reset value
module kd_knn_node_visit_heap #(
  parameter int MAX_K      = knnh_pkg::MAX_K_DEF,
  parameter int COORD_BITS = knnh_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = knnh_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [knnh_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [knnh_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic                          first_node_i,
  input  logic [ID_BITS-1:0]            node_id_i,
  input  logic signed [COORD_BITS-1:0]  node_x_i,
  input  logic signed [COORD_BITS-1:0]  node_y_i,
  input  logic signed [COORD_BITS-1:0]  node_z_i,
  input  logic [1:0]                    split_axis_i,
  input  logic                          has_left_i,
  input  logic                          has_right_i,
  input  logic [knnh_pkg::SLOT_W-1:0]   read_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          visit_left_o,
  output logic                          visit_right_o,
  output logic [knnh_pkg::SLOT_W-1:0]   found_count_o,
  output logic [knnh_pkg::DIST_W-1:0]   radius_sq_o,
  output logic [ID_BITS-1:0]            slot_node_id_o,
  output logic [knnh_pkg::DIST_W-1:0]   slot_dist_sq_o
);
  import knnh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  knnh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  knnh_dp #(
    .MAX_K     (MAX_K),
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .first_node_i  (first_node_i),
    .node_id_i     (node_id_i),
    .node_x_i      (node_x_i),
    .node_y_i      (node_y_i),
    .node_z_i      (node_z_i),
    .split_axis_i  (split_axis_i),
    .has_left_i    (has_left_i),
    .has_right_i   (has_right_i),
    .read_slot_i   (read_slot_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .visit_left_o  (visit_left_o),
    .visit_right_o (visit_right_o),
    .found_count_o (found_count_o),
    .radius_sq_o   (radius_sq_o),
    .slot_node_id_o(slot_node_id_o),
    .slot_dist_sq_o(slot_dist_sq_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

// ===== hw/rtl/knnh_chk.sv =====
// port-level checker for the knn node visit heap, with its bind
`include "kd_knn_node_visit_heap_defines.svh"

module knnh_chk #(
  parameter int ID_BITS = knnh_pkg::ID_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          visit_left_o,
  input logic                          visit_right_o,
  input logic [knnh_pkg::DIST_W-1:0]   radius_sq_o,
  input logic [ID_BITS-1:0]            slot_node_id_o,
  input logic [knnh_pkg::DIST_W-1:0]   slot_dist_sq_o
);

  // a visit word carries no slot contents
  `KNNH_AST_NOW(a_visit_no_slot, out_valid_o && (visit_left_o || visit_right_o), slot_node_id_o == '0 && slot_dist_sq_o == '0)

  // zero radius prunes the far side
  `KNNH_AST_NOW(a_zero_rad_one_side, out_valid_o && radius_sq_o == '0, !(visit_left_o && visit_right_o))

  // one word in flight at a time
  `KNNH_AST_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // stalled result holds
  `KNNH_AST_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(radius_sq_o))

endmodule

bind kd_knn_node_visit_heap knnh_chk #(
  .ID_BITS(ID_BITS)
) u_knnh_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .visit_left_o  (visit_left_o),
  .visit_right_o (visit_right_o),
  .radius_sq_o   (radius_sq_o),
  .slot_node_id_o(slot_node_id_o),
  .slot_dist_sq_o(slot_dist_sq_o)
);
